[hdl/format_string_integer_formatter_unit_assert.svh]
// assertion macros shared by the formatter rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef FORMAT_STRING_INTEGER_FORMATTER_UNIT_ASSERT_SVH
`define FORMAT_STRING_INTEGER_FORMATTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPF_ASSERT(label, prop, msg)
`define TPF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hdl/tpfmt_pkg.sv]
// types, character codes and microcode rom of the integer formatter
// no dependencies
package tpfmt_pkg;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [31:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // microprogram addresses
  typedef logic [3:0] upc_t;
  localparam upc_t A_IDLE = 4'd0;
  localparam upc_t A_ECHO = 4'd1;
  localparam upc_t A_CHR  = 4'd2;
  localparam upc_t A_HEX  = 4'd3;
  localparam upc_t A_I16  = 4'd4;
  localparam upc_t A_I16N = 4'd5;
  localparam upc_t A_L32  = 4'd6;
  localparam upc_t A_L32N = 4'd7;
  localparam upc_t A_DEC  = 4'd8;
  localparam upc_t A_SKIP = 4'd9;
  localparam upc_t A_SUB  = 4'd10;
  localparam upc_t A_DIG  = 4'd11;
  localparam upc_t A_ZERO = 4'd12;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [3:0] K_START16 = 4'd5;
  localparam logic [3:0] K_LASTDEC = 4'd9;
  localparam logic [3:0] K_LASTHEX = 4'd3;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    SEL_INCHR, SEL_LOWBYTE, SEL_MINUS, SEL_DIGIT, SEL_HEX, SEL_ZERO
  } sel_t;

  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_K9, LAST_K3} last_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_NEG16, OP_NEG32, OP_KINC, OP_SUB, OP_NEXTK, OP_HEXSH
  } op_t;

  // next address: sequential, unconditional, conditional or loop-else-idle
  typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_IF, J_LOOP} jmp_t;

  typedef enum logic [2:0] {
    C_POS16, C_POS32, C_ZERO, C_SKIP, C_GE, C_MOREK, C_MOREH
  } cond_t;

  typedef struct packed {
    logic  emit;
    sel_t  sel;
    last_t last;
    op_t   op;
    logic  gate;
    jmp_t  jmp;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic pos16;
    logic pos32;
    logic zero;
    logic skip;
    logic ge;
    logic morek;
    logic moreh;
  } dp_stat_t;

  // datapath control driven by the sequencer
  typedef struct packed {
    logic  load;
    logic  wide;
    logic  k5;
    logic  do_op;
    logic  emit;
    sel_t  sel;
    last_t last;
    op_t   op;
  } dp_ctrl_t;

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    unique case (k)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {4'b0, n};
    end else begin
      c = CH_UA + {4'b0, n - 4'd10};
    end
    return c;
  endfunction

  // microcode rom
  function automatic uword_t urom(input upc_t a);
    uword_t w;
    w = '{emit: 1'b0, sel: SEL_INCHR, last: LAST_NO, op: OP_NONE, gate: 1'b0,
          jmp: J_ALWAYS, cond: C_ZERO, target: A_IDLE};
    case (a)
      A_ECHO: begin
        w.emit = 1'b1; w.sel = SEL_INCHR; w.last = LAST_YES;
      end
      A_CHR: begin
        w.emit = 1'b1; w.sel = SEL_LOWBYTE; w.last = LAST_YES;
      end
      A_HEX: begin
        w.emit = 1'b1; w.sel = SEL_HEX; w.last = LAST_K3; w.op = OP_HEXSH;
        w.jmp = J_LOOP; w.cond = C_MOREH; w.target = A_HEX;
      end
      A_I16: begin
        w.jmp = J_IF; w.cond = C_POS16; w.target = A_DEC;
      end
      A_I16N: begin
        w.emit = 1'b1; w.sel = SEL_MINUS; w.op = OP_NEG16; w.target = A_DEC;
      end
      A_L32: begin
        w.jmp = J_IF; w.cond = C_POS32; w.target = A_DEC;
      end
      A_L32N: begin
        w.emit = 1'b1; w.sel = SEL_MINUS; w.op = OP_NEG32; w.target = A_DEC;
      end
      A_DEC: begin
        w.jmp = J_IF; w.cond = C_ZERO; w.target = A_ZERO;
      end
      A_SKIP: begin
        w.op = OP_KINC; w.gate = 1'b1;
        w.jmp = J_IF; w.cond = C_SKIP; w.target = A_SKIP;
      end
      A_SUB: begin
        w.op = OP_SUB; w.gate = 1'b1;
        w.jmp = J_IF; w.cond = C_GE; w.target = A_SUB;
      end
      A_DIG: begin
        w.emit = 1'b1; w.sel = SEL_DIGIT; w.last = LAST_K9; w.op = OP_NEXTK;
        w.jmp = J_LOOP; w.cond = C_MOREK; w.target = A_SUB;
      end
      A_ZERO: begin
        w.emit = 1'b1; w.sel = SEL_ZERO; w.last = LAST_YES;
      end
      default: begin
        w.jmp = J_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/tpfmt_seq.sv]
// microcode sequencer: step counter, rom, dispatch and percent flag
// depends on tpfmt_pkg and the assertion macro header
`include "format_string_integer_formatter_unit_assert.svh"
module tpfmt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpfmt_pkg::in_item_t in_data,
  input  tpfmt_pkg::dp_stat_t stat,
  input  logic                out_free,
  output tpfmt_pkg::dp_ctrl_t ctrl
);
  import tpfmt_pkg::*;

  upc_t   step_r, step_nxt, disp;
  logic   pend_r, pend_nxt;
  logic   idle, acc, cond_ok, fire, wide, k5;
  uword_t uw;

  assign idle     = (step_r == A_IDLE);
  assign in_ready = idle;
  assign acc      = in_valid && idle;
  assign uw       = urom(step_r);

  // dispatch of a new request to its microprogram entry
  always_comb begin
    disp     = A_IDLE;
    pend_nxt = pend_r;
    wide     = 1'b0;
    k5       = 1'b0;
    if (acc) begin
      priority if (in_data.fmt_char == CH_NUL) begin
        pend_nxt = 1'b0;
      end else if (!pend_r) begin
        if (in_data.fmt_char == CH_PCT) begin
          pend_nxt = 1'b1;
        end else begin
          disp = A_ECHO;
        end
      end else begin
        pend_nxt = 1'b0;
        case (in_data.fmt_char)
          CH_C:    disp = A_CHR;
          CH_I:    begin disp = A_I16; k5 = 1'b1; end
          CH_U:    begin disp = A_DEC; k5 = 1'b1; end
          CH_L:    begin disp = A_L32; wide = 1'b1; end
          CH_N:    begin disp = A_DEC; wide = 1'b1; end
          CH_X:    disp = A_HEX;
          default: disp = A_ECHO;
        endcase
      end
    end
  end

  // condition select
  always_comb begin
    unique case (uw.cond)
      C_POS16: cond_ok = stat.pos16;
      C_POS32: cond_ok = stat.pos32;
      C_ZERO:  cond_ok = stat.zero;
      C_SKIP:  cond_ok = stat.skip;
      C_GE:    cond_ok = stat.ge;
      C_MOREK: cond_ok = stat.morek;
      C_MOREH: cond_ok = stat.moreh;
      default: cond_ok = 1'b0;
    endcase
  end

  // a step stalls only while its character cannot be stored
  assign fire = !idle && (!uw.emit || out_free);

  // next step address
  always_comb begin
    step_nxt = step_r;
    if (idle) begin
      step_nxt = disp;
    end else if (fire) begin
      unique case (uw.jmp)
        J_NEXT:   step_nxt = step_r + 4'd1;
        J_ALWAYS: step_nxt = uw.target;
        J_IF:     step_nxt = cond_ok ? uw.target : step_r + 4'd1;
        J_LOOP:   step_nxt = cond_ok ? uw.target : A_IDLE;
        default:  step_nxt = A_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.load  = acc;
    ctrl.wide  = wide;
    ctrl.k5    = k5;
    ctrl.do_op = fire && (!uw.gate || cond_ok);
    ctrl.emit  = fire && uw.emit;
    ctrl.sel   = uw.sel;
    ctrl.last  = uw.last;
    ctrl.op    = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= A_IDLE;
      pend_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      pend_r <= pend_nxt;
    end
  end

  `TPF_ASSERT(a_step_in_program, step_r <= A_ZERO, "step counter left the program")
  `TPF_ASSERT(a_pct_arms, acc && !pend_r && in_data.fmt_char == CH_PCT |=> pend_r && idle, "percent did not arm")
  `TPF_ASSERT(a_letter_clears, acc && pend_r |=> !pend_r, "pending flag not cleared")
endmodule

[hdl/tpfmt_dp.sv]
// datapath: argument register, power index, digit counter, subtractor, output register
// depends on tpfmt_pkg and the assertion macro header
`include "format_string_integer_formatter_unit_assert.svh"
module tpfmt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tpfmt_pkg::in_item_t  in_data,
  input  tpfmt_pkg::dp_ctrl_t  ctrl,
  output tpfmt_pkg::dp_stat_t  stat,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpfmt_pkg::out_item_t out_data
);
  import tpfmt_pkg::*;

  logic [7:0]  chr_r;
  logic [31:0] val_r, pow;
  logic [3:0]  k_r, digit_r;
  logic        ov_r, lt;
  out_item_t   od_r;
  logic [7:0]  ch;
  logic        lst;

  assign pow = pow10(k_r);
  assign lt  = (val_r < pow);

  // status for the sequencer
  always_comb begin
    stat.pos16 = !val_r[15];
    stat.pos32 = !val_r[31];
    stat.zero  = (val_r == 32'd0);
    stat.skip  = (k_r < K_LASTDEC) && lt;
    stat.ge    = !lt && (digit_r != DIGIT_MAX);
    stat.morek = (k_r != K_LASTDEC);
    stat.moreh = (k_r != K_LASTHEX);
  end

  // character select
  always_comb begin
    unique case (ctrl.sel)
      SEL_INCHR:   ch = chr_r;
      SEL_LOWBYTE: ch = val_r[7:0];
      SEL_MINUS:   ch = CH_MINUS;
      SEL_DIGIT:   ch = CH_ZERO + {4'b0, digit_r};
      SEL_HEX:     ch = hex_char(val_r[15:12]);
      SEL_ZERO:    ch = CH_ZERO;
      default:     ch = CH_ZERO;
    endcase
    unique case (ctrl.last)
      LAST_NO:  lst = 1'b0;
      LAST_YES: lst = 1'b1;
      LAST_K9:  lst = (k_r == K_LASTDEC);
      LAST_K3:  lst = (k_r == K_LASTHEX);
      default:  lst = 1'b0;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      chr_r   <= in_data.fmt_char;
      val_r   <= ctrl.wide ? in_data.arg_value : {16'b0, in_data.arg_value[15:0]};
      k_r     <= ctrl.k5 ? K_START16 : 4'd0;
      digit_r <= 4'd0;
    end else if (ctrl.do_op) begin
      case (ctrl.op)
        OP_NEG16: val_r <= {16'b0, ~val_r[15:0] + 16'd1};
        OP_NEG32: val_r <= ~val_r + 32'd1;
        OP_KINC:  k_r <= k_r + 4'd1;
        OP_SUB: begin
          val_r   <= val_r - pow;
          digit_r <= digit_r + 4'd1;
        end
        OP_NEXTK: begin
          if (k_r != K_LASTDEC) begin
            k_r <= k_r + 4'd1;
          end
          digit_r <= 4'd0;
        end
        OP_HEXSH: begin
          val_r <= {val_r[27:0], 4'b0};
          k_r   <= k_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      od_r <= '{out_char: ch, last: lst};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctrl.emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_free  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  `TPF_ASSERT(a_digit_range, ctrl.emit && ctrl.sel == SEL_DIGIT |-> digit_r <= DIGIT_MAX, "digit above nine")
  `TPF_ASSERT(a_no_overwrite, ctrl.emit |-> out_free, "result overwritten before taken")
  `TPF_ASSERT(a_out_hold, ov_r && !out_ready |=> ov_r && $stable(od_r), "result dropped")
endmodule

[hdl/format_string_integer_formatter_unit.sv]
// Integer formatter: takes one format byte and an argument word per request and
// returns its characters one per result. Echo and char store a single character
// and hex stores its four digits in turn; a zero stores a single 0. A decimal
// first tests for zero, then skips the leading powers of ten, subtracts each power
// until the value is below it, with a final compare for each digit, and stores the
// digit; a signed conversion first tests the sign and, if negative, stores a minus.
// The subtractions are done by the single 32-bit subtractor that the microcode
// steps through. The next request can be taken in the cycle after the last
// character is stored in the output register; a full output register that is not
// taken holds the program on its next character.
// depends on tpfmt_pkg, tpfmt_seq and tpfmt_dp
module format_string_integer_formatter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tpfmt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpfmt_pkg::out_item_t out_data
);
  import tpfmt_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     out_free;

  // sequencer
  tpfmt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // datapath
  tpfmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

[test/format_string_integer_formatter_unit_tb.sv]
`timescale 1ns / 100ps
// testbench for the integer formatter: directed corner requests, then random format sequences
// each character is checked against a behavioural predictor held in a small scoreboard class
// depends on tpfmt_pkg and format_string_integer_formatter_unit
module format_string_integer_formatter_unit_tb;
  import tpfmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PHASE_ITEMS    = 55;
  localparam int PRESSURE_ITEMS = 40;

  // expected characters and the predictor that produces them
  class fmt_scoreboard;
    out_item_t   want_q[$];
    bit          percent_armed;
    int unsigned requests;
    int unsigned chars;
    int unsigned errors;

    task report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function void push_char(input logic [7:0] c);
      out_item_t item;
      item.out_char = c;
      item.last     = 1'b0;
      want_q.push_back(item);
    endfunction

    // decimal digits, no leading zeros, a single zero for zero
    function void push_decimal(input logic [31:0] value);
      logic [7:0] digits[$];
      if (value == 32'd0) begin
        push_char(CH_ZERO);
        return;
      end
      while (value != 32'd0) begin
        digits.push_front(CH_ZERO + 8'(value % 32'd10));
        value = value / 32'd10;
      end
      foreach (digits[j]) push_char(digits[j]);
    endfunction

    // note an accepted request and queue the characters it must give
    function void note_request(input in_item_t r);
      logic [7:0]  ch;
      logic [31:0] arg;
      logic [15:0] lo;
      logic [3:0]  nib;
      int          base;
      out_item_t   tail;
      ch   = r.fmt_char;
      arg  = r.arg_value;
      lo   = arg[15:0];
      base = want_q.size();
      requests++;
      if (ch == CH_NUL) begin
        percent_armed = 1'b0;
        return;
      end
      if (!percent_armed) begin
        if (ch == CH_PCT) begin
          percent_armed = 1'b1;
          return;
        end
        push_char(ch);
      end else begin
        percent_armed = 1'b0;
        case (ch)
          CH_C: push_char(arg[7:0]);
          CH_I: begin
            if (lo[15]) begin
              push_char(CH_MINUS);
              push_decimal({16'd0, 16'd0 - lo});
            end else begin
              push_decimal({16'd0, lo});
            end
          end
          CH_U: push_decimal({16'd0, lo});
          CH_L: begin
            if (arg[31]) begin
              push_char(CH_MINUS);
              push_decimal(32'd0 - arg);
            end else begin
              push_decimal(arg);
            end
          end
          CH_N: push_decimal(arg);
          CH_X: begin
            for (int k = 3; k >= 0; k--) begin
              nib = 4'(lo >> (4 * k));
              push_char((nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_UA + 8'(nib - 4'd10));
            end
          end
          default: push_char(ch);
        endcase
      end
      // flag the final character of this request
      if (want_q.size() > base) begin
        tail      = want_q.pop_back();
        tail.last = 1'b1;
        want_q.push_back(tail);
      end
    endfunction

    task check_char(input out_item_t got);
      out_item_t want;
      chars++;
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  got.out_char, got.last));
        return;
      end
      want = want_q.pop_front();
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h",
                                  got.out_char, want.out_char));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b on 0x%02h, wanted %0b",
                                  got.last, got.out_char, want.last));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned   send_idle   = 0;
  int unsigned   stall_pct   = 0;
  logic          hold_go     = 1'b0;
  logic          hold_taken  = 1'b0;
  int unsigned   hold_left   = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   sent        = 0;
  fmt_scoreboard chk         = new();

  format_string_integer_formatter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // accepted requests and characters
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) chk.note_request(in_data);
    if (rst_n && out_valid && out_ready) chk.check_char(out_data);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d characters still awaited",
               idle_cycles, chk.want_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_req(input logic [7:0] ch, input logic [31:0] arg);
    in_item_t r;
    r.fmt_char  = ch;
    r.arg_value = arg;
    return r;
  endfunction

  // argument words biased towards sign, width and power-of-ten boundaries
  function automatic logic [31:0] rand_arg();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      3: return 32'd0 - $urandom_range(0, 20);
      4: begin
        case ($urandom_range(0, 7))
          0: return 32'h0000_0000;
          1: return 32'h0000_8000;
          2: return 32'h0000_7FFF;
          3: return 32'h0000_FFFF;
          4: return 32'h8000_0000;
          5: return 32'h7FFF_FFFF;
          6: return 32'hFFFF_FFFF;
          default: return {16'($urandom_range(0, 65535)), 16'h8000};
        endcase
      end
      default: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        p = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) p = 32'd0 - p;
        return p;
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(0, 5))
      0: return CH_C;
      1: return CH_I;
      2: return CH_U;
      3: return CH_L;
      4: return CH_N;
      default: return CH_X;
    endcase
  endfunction

  // offer one request, idling first as the current mix asks
  task automatic send_request(input in_item_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_conversion(input logic [7:0] letter, input logic [31:0] arg);
    send_request(make_req(CH_PCT, $urandom));
    send_request(make_req(letter, arg));
  endtask

  // mostly well-formed conversions, some broken sequences and noise
  task automatic play_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_conversion(rand_letter(), rand_arg());
    end else if (pick < 75) begin
      send_conversion(8'($urandom_range(0, 255)), rand_arg());
    end else if (pick < 90) begin
      send_request(make_req(8'($urandom_range(32, 126)), $urandom));
    end else begin
      send_request(make_req(8'($urandom_range(0, 255)), rand_arg()));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: plain bytes, flag handling, each conversion at its extremes
    send_request(make_req(8'h41, 32'h0));
    send_request(make_req(8'hFF, 32'hFFFF_FFFF));
    send_request(make_req(CH_NUL, 32'h0));
    send_request(make_req(CH_PCT, 32'h0));
    send_request(make_req(CH_NUL, 32'h0));
    send_request(make_req(CH_X, 32'h1234));
    send_conversion(CH_PCT, 32'h0);
    send_conversion(8'h73, 32'h5);
    send_conversion(CH_C, 32'hFFFF_FF00);
    send_conversion(CH_I, 32'h0000_8000);
    send_conversion(CH_I, 32'hFFFF_0000);
    send_conversion(CH_U, 32'h0000_FFFF);
    send_conversion(CH_L, 32'h8000_0000);
    send_conversion(CH_N, 32'hFFFF_FFFF);
    send_conversion(CH_X, 32'hABCD_FA9C);

    // random sequences under four idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 50; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 50; end
        default: begin send_idle = 21; stall_pct <= 21; end
      endcase
      for (int unsigned goal = sent + PHASE_ITEMS; sent < goal; ) play_sequence();
    end

    // long output hold-off while requests keep coming, so the input backs up
    send_idle = 0;
    stall_pct <= 0;
    hold_go   <= 1'b1;
    for (int unsigned goal = sent + PRESSURE_ITEMS; sent < goal; ) begin
      send_conversion(rand_letter(), rand_arg());
    end
    in_valid <= 1'b0;

    // drain, then allow for any stray characters
    while (chk.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d characters: corner values, four idle mixes",
             chk.requests, chk.chars);
    $display("and a %0d-cycle output hold-off; %0d mismatches", HOLD_CYCLES, chk.errors);
    if (chk.errors == 0 && chk.want_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/tpfmt_pkg.sv
hdl/tpfmt_seq.sv
hdl/tpfmt_dp.sv
hdl/format_string_integer_formatter_unit.sv
test/format_string_integer_formatter_unit_tb.sv
